### sv/nrmc_pkg.sv
package nrmc_pkg;

    // character codes
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_POINT = 8'h2E;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // character classes passed from front to back
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_DIGIT = 2'd1;
    localparam logic [1:0] KIND_POINT = 2'd2;
    localparam logic [1:0] KIND_COMMA = 2'd3;

    // fields of interest
    localparam logic [3:0] FIELD_TAG   = 4'd0;
    localparam logic [3:0] FIELD_LAT   = 4'd3;
    localparam logic [3:0] FIELD_LON   = 4'd5;
    localparam logic [3:0] FIELD_SPEED = 4'd7;

    localparam logic [2:0]  TAG_CHARS   = 3'd5;
    localparam logic [2:0]  TAG_LEN_MAX = 3'd7;
    localparam logic [39:0] TAG_RESET   = 40'h4750524D43;   // "GPRMC"
    localparam logic [29:0] VALUE_MAX   = 30'd999999999;

    // decoupling queue depth
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic       start;
        logic [1:0] kind;
        logic [7:0] chr;
    } t_tok;

    function automatic logic [9:0] pow10(input logic [1:0] e);
        logic [9:0] p;
        case (e)
            2'd0:    p = 10'd1;
            2'd1:    p = 10'd10;
            2'd2:    p = 10'd100;
            default: p = 10'd1000;
        endcase
        return p;
    endfunction

endpackage

### sv/nrmc_char_if.sv
interface nrmc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       sentence_start;

    modport source (output valid, output char_in, output sentence_start, input ready);
    modport sink   (input valid, input char_in, input sentence_start, output ready);
endinterface

### sv/nrmc_res_if.sv
interface nrmc_res_if;
    logic        valid;
    logic        ready;
    logic        matched;
    logic [29:0] latitude_milli;
    logic [29:0] longitude_milli;
    logic [29:0] speed_milli;

    modport source (output valid, output matched, output latitude_milli,
                    output longitude_milli, output speed_milli, input ready);
    modport sink   (input valid, input matched, input latitude_milli,
                    input longitude_milli, input speed_milli, output ready);
endinterface

### sv/nrmc_front.sv
module nrmc_front import nrmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nrmc_char_if.sink   i_chr,
    output logic        o_tok_valid,
    input  logic        i_tok_ready,
    output t_tok        o_tok
);

    t_tok       r_q [QDEPTH];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    t_tok       w_tok;

    always_comb begin
        w_tok.start = i_chr.sentence_start;
        w_tok.chr   = i_chr.char_in;
        if (i_chr.char_in == CHR_COMMA) begin
            w_tok.kind = KIND_COMMA;
        end else if (i_chr.char_in == CHR_POINT) begin
            w_tok.kind = KIND_POINT;
        end else if (i_chr.char_in >= CHR_ZERO && i_chr.char_in <= CHR_NINE) begin
            w_tok.kind = KIND_DIGIT;
        end else begin
            w_tok.kind = KIND_OTHER;
        end
    end

    assign i_chr.ready = (r_cnt != 2'(QDEPTH));
    assign w_push      = i_chr.valid && i_chr.ready;
    assign o_tok_valid = (r_cnt != 2'd0);
    assign w_pop       = o_tok_valid && i_tok_ready;
    assign o_tok       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH))
        else $error("queue count above depth");

endmodule

### sv/nrmc_back.sv
module nrmc_back import nrmc_pkg::*; #(
    parameter int FRACTION_DIGITS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [39:0] i_cfg_wdata,
    input  logic        i_tok_valid,
    output logic        o_tok_ready,
    input  t_tok        i_tok,
    nrmc_res_if.source  o_res
);

    localparam logic [9:0] SCALE = pow10(2'(FRACTION_DIGITS));

    logic [39:0] r_tag;
    logic [3:0]  r_field,  n_field;
    logic [39:0] r_tsh,    n_tsh;
    logic [2:0]  r_tlen,   n_tlen;
    logic [29:0] r_acc,    n_acc;
    logic        r_pt,     n_pt;
    logic [1:0]  r_fc,     n_fc;
    logic        r_stop,   n_stop;
    logic [29:0] r_lat,    n_lat;
    logic [29:0] r_lon,    n_lon;
    logic        r_done,   n_done;

    logic        r_out_valid;
    logic        r_out_matched;
    logic [29:0] r_out_lat, r_out_lon, r_out_spd;

    logic        w_pop;
    logic        w_res, w_res_matched;
    logic [29:0] w_res_spd;

    assign o_tok_ready = !r_out_valid || o_res.ready;
    assign w_pop       = i_tok_valid && o_tok_ready;

    always_comb begin
        logic [34:0] v;
        logic [3:0]  d;
        logic [1:0]  fc_inc;
        n_field = r_field;  n_tsh  = r_tsh;  n_tlen = r_tlen;
        n_acc   = r_acc;    n_pt   = r_pt;   n_fc   = r_fc;
        n_stop  = r_stop;   n_lat  = r_lat;  n_lon  = r_lon;
        n_done  = r_done;
        w_res = 1'b0; w_res_matched = 1'b0; w_res_spd = '0;
        d      = i_tok.chr[3:0];
        fc_inc = r_fc + 2'd1;
        v      = '0;

        if (i_tok.start) begin
            n_field = '0; n_tsh = '0; n_tlen = '0; n_acc = '0; n_pt = 1'b0;
            n_fc = '0; n_stop = 1'b0; n_lat = '0; n_lon = '0; n_done = 1'b0;
            fc_inc = 2'd1;
        end

        if (!n_done) begin
            if (i_tok.kind != KIND_COMMA) begin
                if (n_field == FIELD_TAG) begin
                    n_tsh = {n_tsh[31:0], i_tok.chr};
                    if (n_tlen < TAG_LEN_MAX) n_tlen = n_tlen + 3'd1;
                end else if (n_field == FIELD_LAT || n_field == FIELD_LON ||
                             n_field == FIELD_SPEED) begin
                    if (!n_stop) begin
                        if (i_tok.kind == KIND_DIGIT) begin
                            if (!n_pt) begin
                                v = ({5'd0, n_acc} << 3) + ({5'd0, n_acc} << 1)
                                    + 35'(d) * 35'(SCALE);
                                n_acc = (v > 35'(VALUE_MAX)) ? VALUE_MAX : v[29:0];
                            end else if (32'(n_fc) < FRACTION_DIGITS) begin
                                n_fc = fc_inc;
                                v = {5'd0, n_acc}
                                    + 35'(d) * 35'(pow10(2'(FRACTION_DIGITS) - fc_inc));
                                n_acc = (v > 35'(VALUE_MAX)) ? VALUE_MAX : v[29:0];
                            end
                        end else if (i_tok.kind == KIND_POINT && !n_pt) begin
                            n_pt = 1'b1;
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                end
            end else begin
                // comma closes the field
                if (n_field == FIELD_TAG &&
                    (n_tlen != TAG_CHARS || n_tsh != r_tag)) begin
                    w_res  = 1'b1;
                    n_done = 1'b1;
                end else if (n_field == FIELD_SPEED) begin
                    w_res = 1'b1; w_res_matched = 1'b1; w_res_spd = n_acc;
                    n_done = 1'b1;
                end else begin
                    if (n_field == FIELD_LAT) n_lat = n_acc;
                    if (n_field == FIELD_LON) n_lon = n_acc;
                    n_field = n_field + 4'd1;
                end
                n_acc = '0; n_pt = 1'b0; n_fc = '0; n_stop = 1'b0;
                if (n_done) begin
                    n_field = '0; n_tsh = '0; n_tlen = '0; n_lat = '0; n_lon = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= TAG_RESET;
        end else if (i_cfg_we) begin
            r_tag <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= '0; r_tsh <= '0; r_tlen <= '0; r_acc <= '0; r_pt <= 1'b0;
            r_fc <= '0; r_stop <= 1'b0; r_lat <= '0; r_lon <= '0; r_done <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_field <= n_field; r_tsh <= n_tsh; r_tlen <= n_tlen;
                r_acc <= n_acc; r_pt <= n_pt; r_fc <= n_fc; r_stop <= n_stop;
                r_lat <= n_lat; r_lon <= n_lon; r_done <= n_done;
            end
            if (w_pop && w_res) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_res) begin
            r_out_matched <= w_res_matched;
            r_out_lat     <= w_res_matched ? r_lat : '0;
            r_out_lon     <= w_res_matched ? r_lon : '0;
            r_out_spd     <= w_res_spd;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.matched         = r_out_matched;
    assign o_res.latitude_milli  = r_out_lat;
    assign o_res.longitude_milli = r_out_lon;
    assign o_res.speed_milli     = r_out_spd;

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_matched |->
            r_out_lat == '0 && r_out_lon == '0 && r_out_spd == '0)
        else $error("mismatch result carries values");

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done |-> r_field <= FIELD_SPEED)
        else $error("field index past speed field");

    a_acc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= VALUE_MAX && r_lat <= VALUE_MAX && r_lon <= VALUE_MAX)
        else $error("value above saturation limit");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && w_res |=> r_done && r_field == '0 && r_tlen == '0)
        else $error("state not cleared after result");

endmodule

### sv/nmea_rmc_field_extractor.sv
// RMC sentence field extractor.
// i_chr (sink): one character per beat plus a start-of-sentence flag.
// o_res (source): one beat per sentence - matched, latitude, longitude and
//   speed, each scaled by 10^FRACTION_DIGITS and saturated at 999999999.
//   A tag mismatch gives matched=0 and zero values at the comma after
//   field 0; a match gives the values at the comma after field 7.
// i_cfg_we / i_cfg_wdata: the five-character tag, first char in [39:32].
//   Write only while the block is idle.
// Structure: the front classifies characters into a 2-entry queue; the back
//   runs the field parser and owns the result register.
// Throughput: one character per cycle, sustained, while o_res drains.
// Path: a closing comma is held in the front queue, then the back registers the result onto o_res.
// Reset (synchronous, active low): tag returns to GPRMC, queue empties and
//   the parser waits for a sentence start; characters before it are dropped.
// Stall: a held result stops the back; the queue fills and i_chr.ready falls
//   once it is full. Nothing is lost.
module nmea_rmc_field_extractor import nrmc_pkg::*; #(
    parameter int FRACTION_DIGITS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [39:0] i_cfg_wdata,
    nrmc_char_if.sink   i_chr,
    nrmc_res_if.source  o_res
);

    logic w_tok_valid;
    logic w_tok_ready;
    t_tok w_tok;

    nrmc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_chr       (i_chr),
        .o_tok_valid (w_tok_valid),
        .i_tok_ready (w_tok_ready),
        .o_tok       (w_tok)
    );

    nrmc_back #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tok_valid (w_tok_valid),
        .o_tok_ready (w_tok_ready),
        .i_tok       (w_tok),
        .o_res       (o_res)
    );

endmodule
